/* hdl/cfba_pkg.sv */
// Shared types and constants of the channel fail bit accumulator.
// Used by the top level, the front part and the back part; depends on nothing.
`default_nettype none

package cfba_pkg;

  // Eight tester channels share one fail byte.
  localparam int LANES = 8;
  localparam int GROUP_W = 5;
  localparam int BYTE_W = 8;
  localparam int CCOUNT_W = 9;
  localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 9'd256;

  // The cursor is five bits wide, so no more than this many groups are ever used.
  localparam int GROUP_LIMIT = 32;

  // Defaults of the top-level parameters.
  localparam int MAX_CHANNELS_DEF = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  // Depth of the queue between front and back and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  // One classified word, handed from the front part to the back part.
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [BYTE_W-1:0]  fail_bits;
    logic [LANES-1:0]   lane_en;
    logic               last;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/channel_fail_bit_accumulator.sv */
// Top level of the channel fail bit accumulator: front classifier, command
// queue, counter back end and result queue. Depends on cfba_pkg and all cfba_ modules.
//
//   Channel   Ports                                   Handshake
//   config    cfg_wr_en, cfg_wr_data                  written when cfg_wr_en is high
//   input     in_fail_bits                            in_push high and in_full low
//   result    out_group_index .. out_count_lane7      out_pop high and out_empty low
//
// One word is taken per clock cycle, sustained while results are popped; the counter memory
// does one row read and one row write per cycle, with forwarding between back-to-back words
// of the same group. A word passes the command queue, update stage and result queue in turn.
// After reset the counters read as zero at once (valid bit per row), so no clearing pass.
// A stalled result side fills the result queue first, then the command queue, then raises in_full.
`default_nettype none

module channel_fail_bit_accumulator #(
  parameter int MAX_CHANNELS = cfba_pkg::MAX_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = cfba_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cfba_pkg::CCOUNT_W-1:0] cfg_wr_data,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [cfba_pkg::BYTE_W-1:0]   in_fail_bits,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic      [cfba_pkg::GROUP_W-1:0]  out_group_index,
  output logic      [cfba_pkg::BYTE_W-1:0]   out_row_byte,
  output logic                               out_last_of_row,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane0,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane1,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane2,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane3,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane4,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane5,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane6,
  output logic      [COUNT_WIDTH-1:0]        out_count_lane7
);

  localparam int CMD_W = $bits(cfba_pkg::cmd_t);
  localparam int RES_W = cfba_pkg::GROUP_W + cfba_pkg::BYTE_W + 1
                         + cfba_pkg::LANES * COUNT_WIDTH;
  localparam int CNT_W = $clog2(cfba_pkg::QUEUE_DEPTH + 1);

  logic              q_push;
  cfba_pkg::cmd_t    q_cmd;
  logic              cq_full;
  logic              cq_empty;
  logic [CMD_W-1:0]  cq_rdata;
  logic [CNT_W-1:0]  cq_count;
  logic              cmd_pop;
  logic              res_push;
  logic [RES_W-1:0]  res_data;
  logic [RES_W-1:0]  rq_rdata;
  logic              rq_full;
  logic [CNT_W-1:0]  rq_count;
  logic              res_pop_fire;

  assign in_full      = cq_full;
  assign res_pop_fire = out_pop && !out_empty;

  // Front part: cursor and lane classification.
  cfba_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_push      (in_push),
    .in_fail_bits (in_fail_bits),
    .q_full       (cq_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  // Command queue between front and back.
  cfba_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (cfba_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_cmd),
    .pop   (cmd_pop),
    .rdata (cq_rdata),
    .full  (cq_full),
    .empty (cq_empty),
    .count (cq_count)
  );

  // Back part: counter update and result assembly.
  cfba_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .COUNT_WIDTH  (COUNT_WIDTH),
    .RES_W        (RES_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (!cq_empty && (cq_count != '0)),
    .cmd          (cfba_pkg::cmd_t'(cq_rdata)),
    .res_count    (rq_count),
    .res_pop_fire (res_pop_fire),
    .cmd_pop      (cmd_pop),
    .res_push     (res_push),
    .res_data     (res_data)
  );

  // Result queue; the back part never pushes into a full queue.
  cfba_fifo #(
    .WIDTH (RES_W),
    .DEPTH (cfba_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push && !rq_full),
    .wdata (res_data),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .full  (rq_full),
    .empty (out_empty),
    .count (rq_count)
  );

  // Unpack the oldest result onto the output ports.
  assign {out_group_index, out_row_byte, out_last_of_row,
          out_count_lane7, out_count_lane6, out_count_lane5, out_count_lane4,
          out_count_lane3, out_count_lane2, out_count_lane1, out_count_lane0} = rq_rdata;

endmodule

`default_nettype wire

/* hdl/cfba_fifo.sv */
// Small register-based queue with push/pop, full/empty and fill count.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module cfba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic                            full,
  output logic                            empty,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push_fire;
  logic             pop_fire;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign empty     = (cnt_r == '0);
  assign count     = cnt_r;
  assign rdata     = ent_r[rd_ptr_r];
  assign push_fire = push && !full;
  assign pop_fire  = pop && !empty;

  // Pointer and count updates, with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop_fire && !push_fire) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      ent_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* hdl/cfba_front.sv */
// Front part: holds the channel count register and the group cursor, and
// classifies each fail word into a command. Depends on cfba_pkg.
`default_nettype none

module cfba_front #(
  parameter int MAX_CHANNELS = cfba_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cfba_pkg::CCOUNT_W-1:0] cfg_wr_data,
  input  wire logic                          in_push,
  input  wire logic [cfba_pkg::BYTE_W-1:0]   in_fail_bits,
  input  wire logic                          q_full,
  output logic                               q_push,
  output cfba_pkg::cmd_t                     q_cmd
);

  localparam int CW = cfba_pkg::CCOUNT_W;
  localparam int GW = cfba_pkg::GROUP_W;

  logic [CW-1:0] ccount_r;
  logic [GW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] n_eff;
  logic [6:0]    groups;
  logic          last;
  logic [cfba_pkg::LANES-1:0] lane_en;

  // Channel count register; counters and cursor are kept across writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r <= cfba_pkg::CCOUNT_RESET;
    end else if (cfg_wr_en) begin
      ccount_r <= cfg_wr_data;
    end
  end

  // Effective channel count, group count and end-of-row detection.
  always_comb begin
    if (32'(ccount_r) > MAX_CHANNELS) begin
      n_eff = CW'(MAX_CHANNELS);
    end else begin
      n_eff = ccount_r;
    end
    groups = 7'(({1'b0, n_eff} + 10'd7) >> 3);
    if (groups == '0) begin
      groups = 7'd1;
    end
    last       = ((7'(cursor_r) + 7'd1) >= groups);
    cursor_nxt = last ? '0 : cursor_r + GW'(1);
  end

  // A lane is active when its channel lies below the effective count.
  always_comb begin
    for (int i = 0; i < cfba_pkg::LANES; i++) begin
      lane_en[i] = ({1'b0, cursor_r, 3'(i)} < n_eff);
    end
  end

  assign q_push          = in_push && !q_full;
  assign q_cmd.group     = cursor_r;
  assign q_cmd.fail_bits = in_fail_bits;
  assign q_cmd.lane_en   = lane_en;
  assign q_cmd.last      = last;

  // The cursor moves on with every accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
    end else if (q_push) begin
      cursor_r <= cursor_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/cfba_back.sv */
// Back part: counter row memory with read-modify-write, forwarding between
// back-to-back words of the same group, and result assembly. Depends on cfba_pkg.
`default_nettype none

module cfba_back #(
  parameter int MAX_CHANNELS = cfba_pkg::MAX_CHANNELS_DEF,
  parameter int COUNT_WIDTH  = cfba_pkg::COUNT_WIDTH_DEF,
  parameter int RES_W        = cfba_pkg::GROUP_W + cfba_pkg::BYTE_W + 1
                               + cfba_pkg::LANES * COUNT_WIDTH
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      cmd_valid,
  input  wire cfba_pkg::cmd_t                            cmd,
  input  wire logic [$clog2(cfba_pkg::QUEUE_DEPTH+1)-1:0] res_count,
  input  wire logic                                      res_pop_fire,
  output logic                                           cmd_pop,
  output logic                                           res_push,
  output logic      [RES_W-1:0]                          res_data
);

  localparam int LANES  = cfba_pkg::LANES;
  localparam int ROW_WD = LANES * COUNT_WIDTH;
  localparam int ROWS_F = (MAX_CHANNELS + LANES - 1) / LANES;
  localparam int ROWS   = (ROWS_F > cfba_pkg::GROUP_LIMIT) ? cfba_pkg::GROUP_LIMIT : ROWS_F;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH  = 1 << ROW_W;
  localparam int CNT_W  = $clog2(cfba_pkg::QUEUE_DEPTH + 1);

  logic [ROW_WD-1:0]  mem_r [DEPTH];
  logic               row_vld_r [DEPTH];
  logic [ROW_WD-1:0]  rdata_r;
  logic               b_valid_r;
  cfba_pkg::cmd_t     b_cmd_r;
  logic               vld_hit_r;
  logic               fwd_r;
  logic [ROW_WD-1:0]  fwd_data_r;
  logic [ROW_W-1:0]   issue_row;
  logic [ROW_W-1:0]   b_row;
  logic [CNT_W:0]     res_used;
  logic               issue;
  logic [ROW_WD-1:0]  old_row;
  logic [ROW_WD-1:0]  new_row;
  logic [ROW_WD-1:0]  out_row;

  assign issue_row = cmd.group[ROW_W-1:0];
  assign b_row     = b_cmd_r.group[ROW_W-1:0];

  // Issue only when the result queue has room for this word as well as the one in flight.
  assign res_used = {1'b0, res_count} + (CNT_W+1)'(b_valid_r) - (CNT_W+1)'(res_pop_fire);
  assign issue    = cmd_valid && (res_used < (CNT_W+1)'(cfba_pkg::QUEUE_DEPTH));
  assign cmd_pop  = issue;

  // Counter memory: one row read on issue, one row written per update.
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem_r[issue_row];
    end
    if (b_valid_r) begin
      mem_r[b_row] <= new_row;
    end
  end

  // Row valid bits; a row never written reads as zero counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < DEPTH; r++) begin
        row_vld_r[r] <= 1'b0;
      end
    end else if (b_valid_r) begin
      row_vld_r[b_row] <= 1'b1;
    end
  end

  // Update stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= issue;
    end
  end

  // Capture the command, and forward the row being written when the next word hits it.
  always_ff @(posedge clk) begin
    if (issue) begin
      b_cmd_r    <= cmd;
      vld_hit_r  <= row_vld_r[issue_row];
      fwd_r      <= b_valid_r && (b_row == issue_row);
      fwd_data_r <= new_row;
    end
  end

  // Saturating increment on each lane, and zeroing of inactive lanes in the result.
  always_comb begin
    if (fwd_r) begin
      old_row = fwd_data_r;
    end else if (vld_hit_r) begin
      old_row = rdata_r;
    end else begin
      old_row = '0;
    end
    new_row = old_row;
    out_row = '0;
    for (int i = 0; i < LANES; i++) begin
      if (b_cmd_r.lane_en[i] && b_cmd_r.fail_bits[i]
          && (old_row[i*COUNT_WIDTH +: COUNT_WIDTH] != '1)) begin
        new_row[i*COUNT_WIDTH +: COUNT_WIDTH] =
          old_row[i*COUNT_WIDTH +: COUNT_WIDTH] + COUNT_WIDTH'(1);
      end
      if (b_cmd_r.lane_en[i]) begin
        out_row[i*COUNT_WIDTH +: COUNT_WIDTH] = new_row[i*COUNT_WIDTH +: COUNT_WIDTH];
      end
    end
  end

  assign res_push = b_valid_r;
  assign res_data = {b_cmd_r.group, b_cmd_r.fail_bits, b_cmd_r.last, out_row};

endmodule

`default_nettype wire
